[src/dmx_pkg.sv]
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared constants, codes and types of the distributed mutex request node.
// ----------------------------------------------------------------------------
package dmx_pkg;

  localparam int DefNodes   = 8;
  localparam int DefSeqBits = 16;
  localparam int IdW        = 3;
  localparam int SeqInW     = 16;
  localparam int EmitMax    = 8;

  // input actions
  localparam logic [1:0] ActInvoke  = 2'd0;
  localparam logic [1:0] ActRequest = 2'd1;
  localparam logic [1:0] ActReply   = 2'd2;
  localparam logic [1:0] ActFinish  = 2'd3;

  // outgoing message kinds
  localparam logic [1:0] KindRequest = 2'd0;
  localparam logic [1:0] KindReply   = 2'd1;
  localparam logic [1:0] KindFlush   = 2'd2;

  typedef enum logic [1:0] {
    QOpHold,
    QOpLoad,
    QOpInsert,
    QOpShift
  } q_op_e;

  typedef enum logic [1:0] {
    CellHold,
    CellKey,
    CellLeft,
    CellRight
  } cell_op_e;

  typedef struct packed {
    logic           full;
    logic           nonempty;
    logic           head_le;
    logic [IdW-1:0] head_id;
  } q_stat_t;

endpackage

[src/dmx_cell.sv]
// ----------------------------------------------------------------------------
// dmx_cell
// One slot of the sorted request queue: holds (seq, id), compares it with the
// key and takes the key or a neighbor's entry as told.
// ----------------------------------------------------------------------------
module dmx_cell #(
  parameter int SeqBits = dmx_pkg::DefSeqBits
) (
  input  logic                     clk_i,
  input  dmx_pkg::cell_op_e        op_i,
  input  logic [SeqBits-1:0]       key_seq_i,
  input  logic [dmx_pkg::IdW-1:0]  key_id_i,
  input  logic [SeqBits-1:0]       left_seq_i,
  input  logic [dmx_pkg::IdW-1:0]  left_id_i,
  input  logic [SeqBits-1:0]       right_seq_i,
  input  logic [dmx_pkg::IdW-1:0]  right_id_i,
  input  logic                     valid_i,
  output logic [SeqBits-1:0]       seq_o,
  output logic [dmx_pkg::IdW-1:0]  id_o,
  output logic                     le_o
);
  import dmx_pkg::*;

  logic [SeqBits-1:0] seq_q, seq_d;
  logic [IdW-1:0]     id_q, id_d;

  always_comb begin
    unique case (op_i)
      CellHold: begin
        seq_d = seq_q;
        id_d  = id_q;
      end
      CellKey: begin
        seq_d = key_seq_i;
        id_d  = key_id_i;
      end
      CellLeft: begin
        seq_d = left_seq_i;
        id_d  = left_id_i;
      end
      CellRight: begin
        seq_d = right_seq_i;
        id_d  = right_id_i;
      end
      default: begin
        seq_d = seq_q;
        id_d  = id_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    id_q  <= id_d;
  end

  // entry does not outrank the key
  assign le_o  = valid_i && ((seq_q < key_seq_i) || ((seq_q == key_seq_i) && (id_q <= key_id_i)));
  assign seq_o = seq_q;
  assign id_o  = id_q;

endmodule

[src/dmx_queue.sv]
// ----------------------------------------------------------------------------
// dmx_queue
// Sorted request queue built as a row of cells with a fill count. Loads a first
// key, inserts a key in order and drops the head one position per cycle.
// ----------------------------------------------------------------------------
module dmx_queue #(
  parameter int Nodes   = dmx_pkg::DefNodes,
  parameter int SeqBits = dmx_pkg::DefSeqBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dmx_pkg::q_op_e           op_i,
  input  logic [SeqBits-1:0]       key_seq_i,
  input  logic [dmx_pkg::IdW-1:0]  key_id_i,
  output dmx_pkg::q_stat_t         stat_o
);
  import dmx_pkg::*;

  localparam int CntW = $clog2(Nodes + 1);

  logic [CntW-1:0]    count_q, count_d;
  logic [SeqBits-1:0] seq_w [Nodes];
  logic [IdW-1:0]     id_w  [Nodes];
  logic [Nodes-1:0]   le_w;
  logic [Nodes-1:0]   valid_w;
  cell_op_e           cop_w [Nodes];

  for (genvar k = 0; k < Nodes; k++) begin : g_cell
    logic [SeqBits-1:0] lseq, rseq;
    logic [IdW-1:0]     lid, rid;
    logic               left_le;

    assign valid_w[k] = count_q > CntW'(k);

    if (k == 0) begin : g_first
      assign lseq    = key_seq_i;
      assign lid     = key_id_i;
      assign left_le = 1'b1;
    end else begin : g_inner
      assign lseq    = seq_w[k-1];
      assign lid     = id_w[k-1];
      assign left_le = le_w[k-1];
    end

    if (k == Nodes - 1) begin : g_last
      assign rseq = seq_w[k];
      assign rid  = id_w[k];
    end else begin : g_more
      assign rseq = seq_w[k+1];
      assign rid  = id_w[k+1];
    end

    always_comb begin
      unique case (op_i)
        QOpHold:   cop_w[k] = CellHold;
        QOpLoad:   cop_w[k] = (k == 0) ? CellKey : CellHold;
        QOpInsert: begin
          // entries ahead of the key stay, the slot after them takes the key
          if (le_w[k])      cop_w[k] = CellHold;
          else if (left_le) cop_w[k] = CellKey;
          else              cop_w[k] = CellLeft;
        end
        QOpShift:  cop_w[k] = CellRight;
        default:   cop_w[k] = CellHold;
      endcase
    end

    dmx_cell #(
      .SeqBits(SeqBits)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (cop_w[k]),
      .key_seq_i  (key_seq_i),
      .key_id_i   (key_id_i),
      .left_seq_i (lseq),
      .left_id_i  (lid),
      .right_seq_i(rseq),
      .right_id_i (rid),
      .valid_i    (valid_w[k]),
      .seq_o      (seq_w[k]),
      .id_o       (id_w[k]),
      .le_o       (le_w[k])
    );
  end

  always_comb begin
    unique case (op_i)
      QOpHold:   count_d = count_q;
      QOpLoad:   count_d = CntW'(1);
      QOpInsert: count_d = count_q + CntW'(1);
      QOpShift:  count_d = count_q - CntW'(1);
      default:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.full     = (count_q == CntW'(Nodes));
  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.head_le  = le_w[0];
  assign stat_o.head_id  = id_w[0];

endmodule

[src/distributed_mutex_request_node.sv]
// ----------------------------------------------------------------------------
// distributed_mutex_request_node
// One node of a token-less distributed mutual exclusion protocol: sorted
// request queue, replied and deferred maps, sequence numbers, and a sequencer
// that emits the messages each action causes.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------
//  action in | start_i, busy_o            | action_i, msg_seq_i, msg_sender_i
//  config    | cfg_we_i                   | cfg_wdata_i (own id)
//  result    | out_strobe_o (one cycle)   | msg_valid_o .. last_o
//
//  busy_o stays high from a transfer until its last result is formed. Invoke,
//  receive request and an ignored reply go straight to the results; other
//  replies and finish first pass a drop phase, in which the queue cells shift
//  the head out one position per cycle while it does not outrank the key.
//  Then the results (1 to 8) leave one a cycle.
//  each result appears in the cycle after it is formed, on a registered output.
//  reset clears the counters and maps at once; queue slots need no clearing.
//  the receiver cannot stall; a new item may start while the last result shows.
// ----------------------------------------------------------------------------
module distributed_mutex_request_node #(
  parameter int NODES    = dmx_pkg::DefNodes,
  parameter int SEQ_BITS = dmx_pkg::DefSeqBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] msg_seq_i,
  input  logic [2:0]  msg_sender_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  output logic        out_strobe_o,
  output logic        msg_valid_o,
  output logic [1:0]  msg_kind_o,
  output logic [2:0]  msg_dest_o,
  output logic [15:0] msg_seq_out_o,
  output logic        may_enter_o,
  output logic        last_o
);
  import dmx_pkg::*;

  localparam int XW = (SEQ_BITS > SeqInW) ? SEQ_BITS : SeqInW;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IdW-1:0]      own_id_q;
  logic [SEQ_BITS-1:0] own_seq_q, own_seq_d;
  logic [SEQ_BITS-1:0] hs_q, hs_d;
  logic [NODES-1:0]    replied_q, replied_d;
  logic [NODES-1:0]    deferred_q, deferred_d;
  logic [NODES-1:0]    pend_q, pend_d;
  logic                requesting_q, requesting_d;
  logic                fin_q, fin_d;
  logic                flush_q, flush_d;
  logic [1:0]          kind_q, kind_d;
  logic [2:0]          emit_cnt_q, emit_cnt_d;
  logic [SEQ_BITS-1:0] key_seq_q, key_seq_d;
  logic [IdW-1:0]      key_id_q, key_id_d;

  logic                strobe_q, strobe_d;
  logic                mvalid_q, mvalid_d;
  logic [1:0]          mkind_q, mkind_d;
  logic [2:0]          mdest_q, mdest_d;
  logic [15:0]         mseq_q, mseq_d;
  logic                menter_q, menter_d;
  logic                last_q, last_d;

  q_op_e               q_op;
  logic [SEQ_BITS-1:0] key_seq;
  logic [IdW-1:0]      key_id;
  q_stat_t             stat;

  logic                accept;
  logic [XW-1:0]       seq_in_ext;
  logic [XW-1:0]       own_seq_ext;
  logic [SEQ_BITS-1:0] ms;
  logic [SEQ_BITS-1:0] seq_next;
  logic [NODES-1:0]    own_bit;
  logic [NODES-1:0]    snd_bit;
  logic                bad_snd;
  logic                may_enter;
  logic [2:0]          pick_dest;
  logic [NODES-1:0]    pend_clr;
  logic                more;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign seq_in_ext  = XW'(msg_seq_i);
  assign ms          = seq_in_ext[SEQ_BITS-1:0];
  assign own_seq_ext = XW'(own_seq_q);
  assign seq_next    = (hs_q == '1) ? hs_q : (hs_q + SEQ_BITS'(1));
  assign own_bit     = (int'(own_id_q) < NODES) ?
                       ({{(NODES-1){1'b0}}, 1'b1} << own_id_q) : '0;
  assign snd_bit     = {{(NODES-1){1'b0}}, 1'b1} << msg_sender_i;
  assign bad_snd     = (int'(msg_sender_i) >= NODES) || (msg_sender_i == own_id_q);
  assign may_enter   = (&replied_q) && stat.nonempty && (stat.head_id == own_id_q);
  assign pend_clr    = pend_q & (pend_q - NODES'(1));

  // lowest pending node
  always_comb begin
    pick_dest = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (pend_q[i]) pick_dest = 3'(i);
    end
  end

  always_comb begin
    state_d      = state_q;
    own_seq_d    = own_seq_q;
    hs_d         = hs_q;
    replied_d    = replied_q;
    deferred_d   = deferred_q;
    pend_d       = pend_q;
    requesting_d = requesting_q;
    fin_d        = fin_q;
    flush_d      = flush_q;
    kind_d       = kind_q;
    emit_cnt_d   = emit_cnt_q;
    key_seq_d    = key_seq_q;
    key_id_d     = key_id_q;
    q_op         = QOpHold;
    key_seq      = key_seq_q;
    key_id       = key_id_q;
    strobe_d     = 1'b0;
    mvalid_d     = mvalid_q;
    mkind_d      = mkind_q;
    mdest_d      = mdest_q;
    mseq_d       = mseq_q;
    menter_d     = menter_q;
    last_d       = 1'b0;
    more         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          emit_cnt_d = '0;
          flush_d    = 1'b0;
          pend_d     = '0;
          kind_d     = KindReply;
          fin_d      = 1'b0;
          state_d    = ST_EMIT;
          unique case (action_i)
            ActInvoke: begin
              own_seq_d    = seq_next;
              key_seq      = seq_next;
              key_id       = own_id_q;
              q_op         = QOpLoad;
              replied_d    = own_bit;
              requesting_d = 1'b1;
              pend_d       = ~own_bit;
              kind_d       = KindRequest;
            end
            ActRequest: begin
              key_seq = ms;
              key_id  = msg_sender_i;
              if (!bad_snd) begin
                if (ms > hs_q) hs_d = ms;
                if (!requesting_q) begin
                  pend_d = snd_bit;
                end else if ((replied_q & snd_bit) == '0) begin
                  replied_d = replied_q | snd_bit;
                  if (!stat.full) q_op = QOpInsert;
                end else begin
                  deferred_d = deferred_q | snd_bit;
                end
              end
            end
            ActReply: begin
              if (!bad_snd) begin
                replied_d = replied_q | snd_bit;
                key_seq_d = ms;
                key_id_d  = msg_sender_i;
                state_d   = ST_DROP;
              end
            end
            ActFinish: begin
              key_seq_d = own_seq_q;
              key_id_d  = own_id_q;
              fin_d     = 1'b1;
              state_d   = ST_DROP;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_DROP: begin
        if (stat.head_le) begin
          q_op = QOpShift;
        end else begin
          state_d = ST_EMIT;
          if (fin_q) begin
            flush_d      = stat.nonempty;
            pend_d       = deferred_q;
            deferred_d   = '0;
            requesting_d = 1'b0;
            kind_d       = KindReply;
          end
        end
      end
      ST_EMIT: begin
        strobe_d   = 1'b1;
        emit_cnt_d = emit_cnt_q + 3'd1;
        menter_d   = may_enter;
        if (flush_q) begin
          mvalid_d = 1'b1;
          mkind_d  = KindFlush;
          mdest_d  = stat.head_id;
          flush_d  = 1'b0;
          more     = (pend_q != '0);
        end else if (pend_q != '0) begin
          mvalid_d = 1'b1;
          mkind_d  = kind_q;
          mdest_d  = pick_dest;
          pend_d   = pend_clr;
          more     = (pend_clr != '0);
        end else begin
          // status item
          mvalid_d = 1'b0;
          mkind_d  = '0;
          mdest_d  = '0;
          more     = 1'b0;
        end
        mseq_d = mvalid_d ? own_seq_ext[SeqInW-1:0] : '0;
        last_d = !more || (emit_cnt_q == 3'(EmitMax - 1));
        if (last_d) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  dmx_queue #(
    .Nodes  (NODES),
    .SeqBits(SEQ_BITS)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (q_op),
    .key_seq_i(key_seq),
    .key_id_i (key_id),
    .stat_o   (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      own_id_q     <= '0;
      own_seq_q    <= '0;
      hs_q         <= '0;
      replied_q    <= '0;
      deferred_q   <= '0;
      pend_q       <= '0;
      requesting_q <= 1'b0;
      fin_q        <= 1'b0;
      flush_q      <= 1'b0;
      kind_q       <= KindRequest;
      emit_cnt_q   <= '0;
      strobe_q     <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) own_id_q <= cfg_wdata_i;
      own_seq_q    <= own_seq_d;
      hs_q         <= hs_d;
      replied_q    <= replied_d;
      deferred_q   <= deferred_d;
      pend_q       <= pend_d;
      requesting_q <= requesting_d;
      fin_q        <= fin_d;
      flush_q      <= flush_d;
      kind_q       <= kind_d;
      emit_cnt_q   <= emit_cnt_d;
      strobe_q     <= strobe_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_seq_q <= key_seq_d;
    key_id_q  <= key_id_d;
    mvalid_q  <= mvalid_d;
    mkind_q   <= mkind_d;
    mdest_q   <= mdest_d;
    mseq_q    <= mseq_d;
    menter_q  <= menter_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign out_strobe_o  = strobe_q;
  assign msg_valid_o   = mvalid_q;
  assign msg_kind_o    = mkind_q;
  assign msg_dest_o    = mdest_q;
  assign msg_seq_out_o = mseq_q;
  assign may_enter_o   = menter_q;
  assign last_o        = last_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("transfer taken but node not busy");

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> out_strobe_o)
    else $error("last marker without a result");

  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !msg_valid_o) |-> last_o)
    else $error("status item not final");

  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_op == QOpShift) |-> (stat.nonempty && (state_q == ST_DROP)))
    else $error("queue shifted while empty or outside drop");

endmodule

[verif/mutex_node_checker.sv]
// ----------------------------------------------------------------------------
// mutex_node_checker
// Watches the action, configuration and result channels of the mutex request
// node, keeps its own model of the node state, predicts the messages every
// accepted action must produce and compares each result field by field.
// ----------------------------------------------------------------------------
module mutex_node_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] msg_seq_i,
  input  logic [2:0]  msg_sender_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        out_strobe_i,
  input  logic        msg_valid_i,
  input  logic [1:0]  msg_kind_i,
  input  logic [2:0]  msg_dest_i,
  input  logic [15:0] msg_seq_out_i,
  input  logic        may_enter_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import dmx_pkg::*;

  localparam int QDepth = 8;

  // (sequence, id) packed so that a plain compare gives the queue order
  typedef struct packed {
    logic [15:0] seq;
    logic [2:0]  id;
  } req_key_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [2:0]  dest;
    logic [15:0] seq;
    logic        enter;
    logic        last;
  } node_msg_t;

  req_key_t    req_keys [QDepth];
  int          req_cnt     = 0;
  logic [7:0]  replied     = '0;
  logic [7:0]  deferred    = '0;
  logic [15:0] own_seq     = '0;
  logic [15:0] seen_max    = '0;
  logic        requesting  = 1'b0;
  logic [2:0]  node_id     = '0;
  node_msg_t   expected_msgs [$];
  int          mismatches  = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // number of queued requests that do not outrank key
  function automatic int lead_count(input req_key_t key);
    int n;
    n = 0;
    while (n < req_cnt && req_keys[n] <= key) n++;
    return n;
  endfunction

  task automatic drop_through(input req_key_t key);
    int n;
    int k;
    n = lead_count(key);
    for (k = n; k < req_cnt; k++) req_keys[k - n] = req_keys[k];
    req_cnt -= n;
  endtask

  function automatic node_msg_t make_msg(input logic [1:0] kind, input logic [2:0] dest);
    node_msg_t m;
    m       = '0;
    m.valid = 1'b1;
    m.kind  = kind;
    m.dest  = dest;
    m.seq   = own_seq;
    return m;
  endfunction

  task automatic predict_node_msgs(input logic [1:0] act, input logic [15:0] s,
                                   input logic [2:0] snd);
    node_msg_t batch [$];
    req_key_t  key;
    logic      enter;
    int        i;
    int        pos;
    key = '{seq: s, id: snd};
    case (act)
      ActInvoke: begin
        own_seq     = (seen_max == 16'hFFFF) ? 16'hFFFF : seen_max + 16'd1;
        req_cnt     = 1;
        req_keys[0] = '{seq: own_seq, id: node_id};
        replied     = '0;
        replied[node_id] = 1'b1;
        requesting  = 1'b1;
        for (i = 0; i < 8; i++)
          if (i != node_id) batch.push_back(make_msg(KindRequest, 3'(i)));
      end
      ActRequest: begin
        if (snd != node_id) begin
          if (s > seen_max) seen_max = s;
          if (!requesting) begin
            batch.push_back(make_msg(KindReply, snd));
          end else if (!replied[snd]) begin
            if (req_cnt < QDepth) begin
              pos = lead_count(key);
              for (i = req_cnt; i > pos; i--) req_keys[i] = req_keys[i - 1];
              req_keys[pos] = key;
              req_cnt++;
            end
            replied[snd] = 1'b1;
          end else begin
            deferred[snd] = 1'b1;
          end
        end
      end
      ActReply: begin
        if (snd != node_id) begin
          replied[snd] = 1'b1;
          drop_through(key);
        end
      end
      default: begin
        drop_through('{seq: own_seq, id: node_id});
        if (req_cnt > 0) batch.push_back(make_msg(KindFlush, req_keys[0].id));
        // at most eight messages leave for one action
        for (i = 0; i < 8; i++)
          if (deferred[i] && batch.size() < 8) batch.push_back(make_msg(KindReply, 3'(i)));
        deferred   = '0;
        requesting = 1'b0;
      end
    endcase
    // an action with nothing to send still reports status
    if (batch.size() == 0) batch.push_back('0);
    enter = (replied == 8'hFF) && (req_cnt > 0) && (req_keys[0].id == node_id);
    foreach (batch[j]) begin
      batch[j].enter = enter;
      batch[j].last  = (j == batch.size() - 1);
      expected_msgs.push_back(batch[j]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    node_msg_t got;
    node_msg_t want;
    if (!rst_ni) begin
      req_cnt    = 0;
      replied    = '0;
      deferred   = '0;
      own_seq    = '0;
      seen_max   = '0;
      requesting = 1'b0;
      node_id    = '0;
      expected_msgs.delete();
    end else begin
      if (out_strobe_i) begin
        got = {msg_valid_i, msg_kind_i, msg_dest_i, msg_seq_out_i, may_enter_i, last_i};
        if (expected_msgs.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%06h", got));
        end else begin
          want = expected_msgs.pop_front();
          check_field("msg_valid", got.valid, want.valid);
          check_field("msg_kind", got.kind, want.kind);
          check_field("msg_dest", got.dest, want.dest);
          check_field("msg_seq_out", got.seq, want.seq);
          check_field("may_enter", got.enter, want.enter);
          check_field("last", got.last, want.last);
        end
      end
      if (start_i && !busy_i) predict_node_msgs(action_i, msg_seq_i, msg_sender_i);
      if (cfg_we_i) node_id = cfg_wdata_i;
    end
    pending_o    <= expected_msgs.size();
    fail_count_o <= mismatches;
  end

endmodule

[verif/tb_distributed_mutex_request_node.sv]
// ----------------------------------------------------------------------------
// tb_distributed_mutex_request_node
// Drives protocol actions into the mutex request node: a directed walk through
// every action and corner, then random request rounds (invoke, replies and
// requests from peers, finish) mixed with stray traffic, under several own ids.
// ----------------------------------------------------------------------------
module tb_distributed_mutex_request_node;
  import dmx_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int RandomItems   = 236;
  localparam int GapEnd        = 200;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start_i      = 1'b0;
  logic [1:0]  action_i     = '0;
  logic [15:0] msg_seq_i    = '0;
  logic [2:0]  msg_sender_i = '0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_wdata_i  = '0;
  logic        busy_o;
  logic        out_strobe_o;
  logic        msg_valid_o;
  logic [1:0]  msg_kind_o;
  logic [2:0]  msg_dest_o;
  logic [15:0] msg_seq_out_o;
  logic        may_enter_o;
  logic        last_o;
  int          fail_count;
  int          pending;

  int          idle_cycles = 0;
  int          items_sent  = 0;
  bit          gaps_on     = 1'b1;
  logic [2:0]  cur_id      = '0;
  int          seq_hi      = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  distributed_mutex_request_node DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .msg_seq_i    (msg_seq_i),
    .msg_sender_i (msg_sender_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_strobe_o (out_strobe_o),
    .msg_valid_o  (msg_valid_o),
    .msg_kind_o   (msg_kind_o),
    .msg_dest_o   (msg_dest_o),
    .msg_seq_out_o(msg_seq_out_o),
    .may_enter_o  (may_enter_o),
    .last_o       (last_o)
  );

  mutex_node_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .action_i     (action_i),
    .msg_seq_i    (msg_seq_i),
    .msg_sender_i (msg_sender_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_strobe_i (out_strobe_o),
    .msg_valid_i  (msg_valid_o),
    .msg_kind_i   (msg_kind_o),
    .msg_dest_i   (msg_dest_o),
    .msg_seq_out_i(msg_seq_out_o),
    .may_enter_i  (may_enter_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // ends the run when neither an action nor a result moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || out_strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("distributed_mutex_request_node test failed");
        $finish;
      end
    end
  end

  task automatic pause_sender(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // one action transfer; start stays high so the next one can follow directly
  task automatic send_action(input logic [1:0] act, input logic [15:0] s,
                             input logic [2:0] snd);
    if (gaps_on && items_sent < GapEnd && $urandom_range(0, 2) == 0)
      pause_sender($urandom_range(1, 12));
    start_i      <= 1'b1;
    action_i     <= act;
    msg_seq_i    <= s;
    msg_sender_i <= snd;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic drain_node();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
  endtask

  task automatic write_own_id(input logic [2:0] id);
    drain_node();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_id = id;
  endtask

  function automatic logic [2:0] pick_other();
    return 3'((int'(cur_id) + 1 + int'($urandom_range(0, 6))) % 8);
  endfunction

  // request sequence near the current front of the protocol
  function automatic logic [15:0] peer_seq();
    int v;
    v = seq_hi + int'($urandom_range(0, 4)) - 2;
    if (v > seq_hi) seq_hi = v;
    return 16'(v);
  endfunction

  task automatic send_stray();
    logic [1:0] act;
    logic [2:0] snd;
    act = 2'($urandom_range(0, 3));
    snd = 3'($urandom_range(0, 7));
    if (act == ActRequest && snd != cur_id) send_action(act, peer_seq(), snd);
    else send_action(act, 16'($urandom), snd);
  endtask

  task automatic run_round();
    int unsigned order [$];
    int unsigned tmp;
    int          i;
    int          k;
    logic [15:0] s;
    repeat ($urandom_range(0, 2)) send_stray();
    seq_hi++;
    send_action(ActInvoke, 16'($urandom), 3'($urandom));
    for (i = 0; i < 8; i++) if (i != cur_id) order.push_back(i);
    for (i = order.size() - 1; i > 0; i--) begin
      k        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    foreach (order[j]) begin
      case ($urandom_range(0, 9))
        0: ;  // this peer stays silent
        1, 2, 3, 4, 5: send_action(ActRequest, peer_seq(), 3'(order[j]));
        default: begin
          case ($urandom_range(0, 7))
            0:       s = 16'($urandom);
            1, 2:    s = 16'(seq_hi + 1 - int'($urandom_range(0, 2)));
            default: s = '0;
          endcase
          send_action(ActReply, s, 3'(order[j]));
        end
      endcase
      // at times a further request from this peer, deferred if the peer already answered
      if ($urandom_range(0, 5) == 0) send_action(ActRequest, peer_seq(), 3'(order[j]));
    end
    if ($urandom_range(0, 3) == 0) send_stray();
    send_action(ActFinish, 16'($urandom), 3'($urandom));
    repeat ($urandom_range(0, 2)) send_action(ActReply, 16'($urandom), pick_other());
  endtask

  initial begin
    logic [2:0] phase_ids [4];
    int         phase;
    int         next_switch;
    logic [2:0] peer_a;
    logic [2:0] peer_b;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk with the highest own id
    write_own_id(3'd7);
    send_action(ActFinish, 16'd0, 3'd0);
    send_action(ActRequest, 16'd3, 3'd0);
    send_action(ActRequest, 16'hFFFF, 3'd7);
    send_action(ActReply, 16'hFFFF, 3'd7);
    send_action(ActReply, 16'd0, 3'd0);
    send_action(ActInvoke, 16'd0, 3'd0);
    send_action(ActRequest, 16'd2, 3'd3);
    send_action(ActRequest, 16'd4, 3'd5);
    send_action(ActRequest, 16'd9, 3'd3);
    send_action(ActReply, 16'd0, 3'd0);
    send_action(ActReply, 16'd0, 3'd1);
    send_action(ActReply, 16'd0, 3'd2);
    send_action(ActReply, 16'd0, 3'd4);
    send_action(ActReply, 16'd0, 3'd6);
    send_action(ActReply, 16'd2, 3'd3);
    send_action(ActReply, 16'd4, 3'd5);
    send_action(ActRequest, 16'd10, 3'd6);
    send_action(ActFinish, 16'd0, 3'd0);
    send_action(ActRequest, 16'd0, 3'd1);
    send_action(ActInvoke, 16'd0, 3'd0);
    send_action(ActRequest, 16'd5, 3'd2);
    send_action(ActRequest, 16'd20, 3'd4);
    send_action(ActFinish, 16'd0, 3'd0);
    send_action(ActReply, 16'hFFFF, 3'd4);

    // random rounds, own id changing between phases
    seq_hi      = 24;
    phase_ids   = '{3'd0, 3'($urandom), 3'd7, 3'($urandom)};
    phase       = 0;
    next_switch = items_sent + 65;
    write_own_id(phase_ids[0]);
    while (items_sent < RandomItems) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_round();
      if ($urandom_range(0, 4) == 0) drain_node();
      if (items_sent >= next_switch && phase < 3) begin
        phase++;
        next_switch = items_sent + 65;
        write_own_id(phase_ids[phase]);
      end
    end

    // sequence number saturation: peer at the top value, then two invokes
    peer_a = pick_other();
    peer_b = 3'((int'(peer_a) + 1) % 8 == cur_id ? (int'(peer_a) + 2) % 8
                                                 : (int'(peer_a) + 1) % 8);
    send_action(ActFinish, 16'd0, 3'd0);
    send_action(ActRequest, 16'hFFFF, peer_a);
    send_action(ActInvoke, 16'd0, 3'd0);
    send_action(ActRequest, 16'hFFFF, peer_b);
    send_action(ActFinish, 16'd0, 3'd0);
    send_action(ActInvoke, 16'd0, 3'd0);
    send_action(ActFinish, 16'd0, 3'd0);

    drain_node();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("distributed_mutex_request_node test passed");
    end else begin
      $display("distributed_mutex_request_node test failed");
    end
    $finish;
  end

endmodule
